// ===== sv/bts_pkg.sv =====
package bts_pkg;

   localparam int TARGET_BITS = 16;

   localparam logic [7:0] OP_JMP      = 8'hC3;
   localparam logic [7:0] OP_CALL     = 8'hCD;
   localparam logic [7:0] MASK_CC     = 8'hC7;
   localparam logic [7:0] OP_JCC      = 8'hC2;
   localparam logic [7:0] OP_CCC      = 8'hC4;
   localparam logic [7:0] MASK_RP     = 8'hCF;
   localparam logic [7:0] OP_LXI      = 8'h01;
   localparam logic [7:0] OP_SHLD     = 8'h22;
   localparam logic [7:0] OP_LHLD     = 8'h2A;
   localparam logic [7:0] OP_STA      = 8'h32;
   localparam logic [7:0] OP_LDA      = 8'h3A;
   localparam logic [7:0] OP_MVI      = 8'h06;
   localparam logic [7:0] OP_ALU_IMM  = 8'hC6;
   localparam logic [7:0] OP_OUT      = 8'hD3;
   localparam logic [7:0] OP_IN       = 8'hDB;

   typedef struct packed {
      logic [15:0] byte_address;
      logic [7:0]  byte_value;
      logic        final_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] target_address;
      logic        operand_missing;
   } rsp_type;

   // one beat's worth of seen-map work handed from the scanner to the filter
   typedef struct packed {
      logic                   resolve;
      logic [TARGET_BITS-1:0] target;
      logic                   missing;
      logic                   flush;
   } cand_type;

   typedef struct packed {
      logic busy;
      logic take;
   } stat_type;

   function automatic logic is_branch(input logic [7:0] op);
      return op == OP_JMP || op == OP_CALL ||
             (op & MASK_CC) == OP_JCC || (op & MASK_CC) == OP_CCC;
   endfunction

   function automatic logic [1:0] op_size(input logic [7:0] op);
      logic [1:0] size;
      size = 2'd1;
      if (is_branch(op) || (op & MASK_RP) == OP_LXI || op == OP_SHLD ||
          op == OP_LHLD || op == OP_STA || op == OP_LDA) begin
         size = 2'd3;
      end else if ((op & MASK_CC) == OP_MVI || (op & MASK_CC) == OP_ALU_IMM ||
                   op == OP_OUT || op == OP_IN) begin
         size = 2'd2;
      end
      return size;
   endfunction

endpackage

// ===== sv/bts_ram.sv =====
module bts_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/bts_scan.sv =====
module bts_scan #(
   parameter int ADDR_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  bts_pkg::req_type  req,
   output bts_pkg::cand_type cand
);
   import bts_pkg::*;

   logic [ADDR_BITS:0]   next_ff, next_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_BITS-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]           low_ff, low_in;
   logic                 low_seen_ff, low_seen_in;

   logic [ADDR_BITS:0]   ax, first, second;
   logic [7:0]           v;
   logic                 resolve, missing, opcode, branch, pend_after;

   always_comb begin
      ax      = {1'b0, req.byte_address[ADDR_BITS-1:0]};
      v       = req.byte_value;
      first   = {1'b0, pend_addr_ff} + (ADDR_BITS+1)'(1);
      second  = {1'b0, pend_addr_ff} + (ADDR_BITS+1)'(2);
      resolve = pend_ff && (ax >= second);
      missing = !((ax == second) && low_seen_ff);
      opcode  = ax >= next_ff;
      branch  = opcode && is_branch(v);

      next_in      = next_ff;
      pend_addr_in = pend_addr_ff;
      low_in       = low_ff;
      low_seen_in  = low_seen_ff;
      pend_after   = pend_ff && !resolve;

      if (pend_ff && ax == first) begin
         low_in      = v;
         low_seen_in = 1'b1;
      end
      if (opcode) begin
         next_in = ax + (ADDR_BITS+1)'(op_size(v));
      end
      if (branch) begin
         pend_after   = 1'b1;
         pend_addr_in = ax[ADDR_BITS-1:0];
         low_in       = 8'h00;
         low_seen_in  = 1'b0;
      end
      pend_in = pend_after && !req.final_byte;

      cand.resolve = resolve;
      cand.missing = missing;
      cand.target  = missing ? '0 : {v, low_ff};
      cand.flush   = req.final_byte && pend_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff      <= '0;
         pend_ff      <= 1'b0;
         pend_addr_ff <= '0;
         low_ff       <= 8'h00;
         low_seen_ff  <= 1'b0;
      end else if (accept) begin
         next_ff      <= next_in;
         pend_ff      <= pend_in;
         pend_addr_ff <= pend_addr_in;
         low_ff       <= low_in;
         low_seen_ff  <= low_seen_in;
      end
   end

endmodule

// ===== sv/bts_filter.sv =====
module bts_filter #(
   parameter int ADDR_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  bts_pkg::cand_type cand,
   output bts_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bts_pkg::rsp_type  rsp_data
);
   import bts_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = '1;

   logic                 clr_busy_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;

   logic                 s1_valid_ff;
   cand_type             s1_cand_ff;
   logic                 fwd_valid_ff;
   logic [ADDR_BITS-1:0] fwd_addr_ff;
   logic                 zero_seen_ff, zero_seen_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [ADDR_BITS-1:0] rd_addr, s1_addr, wr_addr;
   logic                 rd_en, wr_en, s1_we, seen_bit;
   logic                 adv, fire, t_new, emit;

   assign rd_addr = cand.target[ADDR_BITS-1:0];
   assign rd_en   = accept && cand.resolve && (rd_addr != '0);
   assign s1_addr = s1_cand_ff.target[ADDR_BITS-1:0];
   assign adv     = !rsp_valid_ff || rsp_ready;
   assign fire    = s1_valid_ff && adv;

   always_comb begin
      s1_we = fire && s1_cand_ff.resolve && (s1_addr != '0);
      if (s1_addr == '0) begin
         t_new = !zero_seen_ff;
      end else begin
         t_new = !(seen_bit || (fwd_valid_ff && fwd_addr_ff == s1_addr));
      end

      zero_seen_in = zero_seen_ff;
      emit         = 1'b0;
      rsp_data_in.target_address  = 16'(s1_addr);
      rsp_data_in.operand_missing = s1_cand_ff.missing;
      if (s1_cand_ff.resolve && t_new) begin
         emit = 1'b1;
      end
      if (s1_cand_ff.resolve && s1_addr == '0) begin
         zero_seen_in = 1'b1;
      end
      // final flush offers target zero unless this beat already emits a target or zero was seen
      if (s1_cand_ff.flush) begin
         if (!emit && !zero_seen_in) begin
            emit = 1'b1;
            rsp_data_in.target_address  = 16'h0000;
            rsp_data_in.operand_missing = 1'b1;
         end
         zero_seen_in = 1'b1;
      end

      wr_en   = clr_busy_ff || s1_we;
      wr_addr = clr_busy_ff ? clr_addr_ff : s1_addr;
   end

   bts_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_seen_map (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (!clr_busy_ff),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (seen_bit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         zero_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               clr_busy_ff <= 1'b0;
            end
         end
         // capture the write that races this beat's read
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            fwd_valid_ff <= s1_we;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            zero_seen_ff <= zero_seen_in;
            rsp_valid_ff <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cand_ff  <= cand;
         fwd_addr_ff <= s1_addr;
      end
      if (fire && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign stat.busy = clr_busy_ff;
   assign stat.take = !clr_busy_ff && adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/branch_target_scanner_8080.sv =====
// Scans an 8080 program image streamed as ascending (address, byte) beats and
// reports each jump or call target the first time it is found, in discovery
// order. One beat is taken every cycle unless the sweep runs or a held result
// stalls the output; a result passes through the stage-1 register and then
// the output register. The rate is set by the single read port of the seen
// map, read at the beat's accept and written back from the stage-1 register
// with forwarding of the racing write. After reset all 2**ADDR_BITS entries
// (65536 by default) are swept clear, one per cycle, with req_ready low.
module branch_target_scanner_8080 #(
   parameter int ADDR_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bts_pkg::rsp_type rsp_data
);
   import bts_pkg::*;

   cand_type cand;
   stat_type stat;
   logic     accept;

   assign req_ready = stat.take;
   assign accept    = req_valid && req_ready;

   bts_scan #(
      .ADDR_BITS (ADDR_BITS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cand   (cand)
   );

   bts_filter #(
      .ADDR_BITS (ADDR_BITS)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cand      (cand),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_no_take_in_sweep: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !req_ready)
      else $error("beat taken during seen-map sweep");

   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready high right after reset");

   a_missing_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.operand_missing) |-> rsp_data.target_address == 16'h0000)
      else $error("missing operand with nonzero target");

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=>
         !(rsp_valid && rsp_data.target_address == $past(rsp_data.target_address)))
      else $error("same target reported twice in a row");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import bts_pkg::*;

   localparam int ADDR_BITS      = 16;
   localparam int ADDR_MASK      = (1 << ADDR_BITS) - 1;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int RANDOM_ITEMS   = 340;
   localparam logic [7:0] OP_NOP = 8'h00;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // scanner state as the block should hold it
   logic [16:0] scan_next     = '0;
   bit          scan_pending  = 1'b0;
   logic [15:0] scan_op_addr  = '0;
   logic [7:0]  scan_low      = '0;
   bit          scan_low_seen = 1'b0;
   bit          seen_map [0:(1 << ADDR_BITS) - 1];

   rsp_type     target_q[$];
   logic [15:0] known_targets[$];
   rsp_type     rsp_want;

   int cursor     = 0;
   int items_sent = 0;
   int err_cnt    = 0;
   bit idle_on    = 1'b1;
   bit hold_req   = 1'b0;

   branch_target_scanner_8080 #(.ADDR_BITS(ADDR_BITS)) DUT (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit is_transfer(input logic [7:0] op);
      return op == OP_JMP || op == OP_CALL || (op & MASK_CC) inside {OP_JCC, OP_CCC};
   endfunction

   function automatic int opcode_length(input logic [7:0] op);
      if (is_transfer(op) || (op & MASK_RP) == OP_LXI ||
          op inside {OP_SHLD, OP_LHLD, OP_STA, OP_LDA}) begin
         return 3;
      end
      if ((op & MASK_CC) inside {OP_MVI, OP_ALU_IMM} || op inside {OP_OUT, OP_IN}) begin
         return 2;
      end
      return 1;
   endfunction

   function automatic logic [7:0] pick_opcode(input int len, input bit jump);
      logic [7:0] op;
      do op = 8'($urandom_range(255));
      while (opcode_length(op) != len || is_transfer(op) != jump);
      return op;
   endfunction

   // mark the target and queue it, unless already reported or this beat has one
   function automatic void claim_target(input logic [15:0] tgt, input logic missing,
                                        inout bit hit);
      logic [15:0] t;
      t = 16'(tgt & ADDR_MASK);
      if (seen_map[t]) return;
      seen_map[t] = 1'b1;
      if (!hit) begin
         target_q.push_back('{target_address: t, operand_missing: missing});
         known_targets.push_back(t);
         hit = 1'b1;
      end
   endfunction

   function automatic void track_target(input req_type beat);
      int a;
      bit hit;
      a = int'(beat.byte_address) & ADDR_MASK;
      hit = 1'b0;
      if (scan_pending) begin
         if (a == scan_op_addr + 1) begin
            scan_low = beat.byte_value;
            scan_low_seen = 1'b1;
         end else if (a >= scan_op_addr + 2) begin
            if (a == scan_op_addr + 2 && scan_low_seen) begin
               claim_target({beat.byte_value, scan_low}, 1'b0, hit);
            end else begin
               claim_target('0, 1'b1, hit);
            end
            scan_pending = 1'b0;
         end
      end
      if (a >= scan_next) begin
         scan_next = 17'(a + opcode_length(beat.byte_value));
         if (is_transfer(beat.byte_value)) begin
            scan_pending  = 1'b1;
            scan_op_addr  = 16'(a);
            scan_low      = '0;
            scan_low_seen = 1'b0;
         end
      end
      if (beat.final_byte && scan_pending) begin
         claim_target('0, 1'b1, hit);
         scan_pending = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what);
      err_cnt++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic send_byte(input logic [15:0] addr, input logic [7:0] val, input logic fin);
      req_type beat;
      logic    taken;
      beat = '{byte_address: addr, byte_value: val, final_byte: fin};
      if (idle_on && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      taken = 1'b0;
      while (!taken) begin
         // inputs move only at rising edges, so the falling edge sees settled values
         @(negedge clock);
         taken = req_ready;
         if (taken) track_target(beat);
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic put_byte(input logic [7:0] val, input logic fin);
      send_byte(16'(cursor), val, fin);
      cursor++;
   endtask

   task automatic emit_insn(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi);
      int len;
      len = opcode_length(op);
      // land on an opcode boundary
      if (cursor < scan_next) cursor = int'(scan_next);
      put_byte(op, 1'b0);
      if (len > 1) put_byte(lo, 1'b0);
      if (len > 2) put_byte(hi, 1'b0);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (target_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      idle_on = 1'b1;
      cursor  = 0;
      put_byte(OP_NOP, 1'b0);
      // second operand absent: the byte after it resolves the target as missing
      put_byte(OP_JMP, 1'b0);
      put_byte(8'h34, 1'b0);
      cursor++;
      put_byte(OP_NOP, 1'b0);
      emit_insn(OP_CALL, 8'hFF, 8'hFF);
      emit_insn(OP_JMP, 8'h34, 8'h12);
      emit_insn(OP_JMP, 8'h34, 8'h12);
      // first operand absent
      if (cursor < scan_next) cursor = int'(scan_next);
      put_byte(OP_CCC, 1'b0);
      cursor++;
      put_byte(8'h56, 1'b0);
      // repeated first operand overwrites the low byte
      if (cursor < scan_next) cursor = int'(scan_next);
      put_byte(OP_JCC, 1'b0);
      put_byte(8'h11, 1'b0);
      send_byte(16'(cursor - 1), 8'h22, 1'b0);
      put_byte(8'h33, 1'b0);
      // operands that look like branches are not decoded
      emit_insn(OP_MVI, OP_JMP, 8'h00);
      emit_insn(OP_LXI, OP_JMP, OP_CALL);
      emit_insn(OP_CALL, 8'hCD, 8'hAB);
      put_byte(OP_JCC, 1'b1);
      // the scan goes on after the final byte
      emit_insn(OP_CALL, 8'h00, 8'h80);
      stop_sending();
      wait_drain();
   endtask

   task automatic test_random_program();
      int          choice;
      logic [15:0] tgt;
      logic [7:0]  op;
      while (items_sent < RANDOM_ITEMS) begin
         idle_on = ((items_sent / 60) % 3) != 2;
         choice  = $urandom_range(99);
         if (choice < 55) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: begin
                  if (known_targets.size() != 0 && $urandom_range(6) == 0) begin
                     tgt = known_targets[$urandom_range(known_targets.size() - 1)];
                  end else begin
                     tgt = 16'($urandom);
                  end
                  emit_insn(pick_opcode(3, 1'b1), tgt[7:0], tgt[15:8]);
               end
               5, 6: emit_insn(pick_opcode(3, 1'b0), 8'($urandom), 8'($urandom));
               7: emit_insn(pick_opcode(2, 1'b0), 8'($urandom), 8'h00);
               default: emit_insn(pick_opcode(1, 1'b0), 8'h00, 8'h00);
            endcase
         end else if (choice < 65) begin
            // branch with one or both operands dropped
            op = pick_opcode(3, 1'b1);
            if (cursor < scan_next) cursor = int'(scan_next);
            put_byte(op, 1'b0);
            case ($urandom_range(2))
               0: begin
                  cursor++;
                  put_byte(8'($urandom), 1'b0);
               end
               1: begin
                  put_byte(8'($urandom), 1'b0);
                  cursor++;
               end
               default: cursor += 2;
            endcase
         end else if (choice < 80) begin
            put_byte(8'($urandom), 1'b0);
         end else if (choice < 88) begin
            if (cursor < 'hC000 && $urandom_range(7) == 0) cursor += $urandom_range(4096, 256);
            else cursor += $urandom_range(40, 1);
         end else if (choice < 93) begin
            if (cursor >= 4) send_byte(16'(cursor - $urandom_range(3, 1)), 8'($urandom), 1'b0);
         end else begin
            put_byte(8'($urandom), 1'b1);
         end
      end
      stop_sending();
      wait_drain();
   endtask

   task automatic test_backpressure();
      logic [15:0] tgt;
      idle_on  = 1'b0;
      hold_req = 1'b1;
      repeat (30) begin
         tgt = 16'($urandom);
         emit_insn(pick_opcode(3, 1'b1), tgt[7:0], tgt[15:8]);
      end
      stop_sending();
      wait (!hold_req);
      wait_drain();
   endtask

   task automatic test_address_top();
      idle_on = 1'b0;
      cursor  = 'hFFF8;
      emit_insn(OP_LXI, 8'h01, 8'h02);
      emit_insn(OP_CALL, 8'h78, 8'h56);
      // second operand would sit past the top of the address space
      put_byte(OP_JMP, 1'b0);
      put_byte(8'h99, 1'b1);
      // past the top nothing decodes any more
      send_byte(16'h0010, OP_JMP, 1'b0);
      send_byte(16'h8000, OP_CALL, 1'b1);
      stop_sending();
      wait_drain();
   endtask

   // result side: random stalls, plus one long hold when asked
   initial begin
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (target_q.size() == 0) begin
            report_mismatch($sformatf("target %h missing %b with nothing expected",
                                      rsp_data.target_address, rsp_data.operand_missing));
         end else begin
            rsp_want = target_q.pop_front();
            if (rsp_data.target_address !== rsp_want.target_address) begin
               report_mismatch($sformatf("target_address %h, expected %h",
                                         rsp_data.target_address, rsp_want.target_address));
            end
            if (rsp_data.operand_missing !== rsp_want.operand_missing) begin
               report_mismatch($sformatf("operand_missing %b, expected %b for target %h",
                                         rsp_data.operand_missing, rsp_want.operand_missing,
                                         rsp_want.target_address));
            end
         end
      end
   end

   // covers the seen-map clearing after reset as well
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("[branch_target_scanner_8080] ERROR");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_program();
      test_backpressure();
      test_address_top();
      repeat (16) @(posedge clock);
      if (err_cnt == 0) begin
         $display("[branch_target_scanner_8080] OK");
      end else begin
         $display("[branch_target_scanner_8080] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bts_pkg.sv
sv/bts_ram.sv
sv/bts_scan.sv
sv/bts_filter.sv
sv/branch_target_scanner_8080.sv
sim/tb.sv
